// ===== src/tsw_pkg.sv =====
`default_nettype none

package tsw_pkg;

  // defaults for the top-level parameters
  localparam int MAX_DIM_DEF         = 64;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int WEIGHT_BITS_DEF     = 8;

  // fixed field widths
  localparam int TEXEL_W    = 32;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 4;
  localparam int INDEX_W    = 12;
  localparam int COORD_W    = 32;
  localparam int S_TDATA_W  = 112;
  localparam int M_TDATA_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int SIZE_W     = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT  = 2'd3;

  // wrap modes, the unused code behaves as clamp
  localparam logic [1:0] WRAP_CLAMP  = 2'd0;
  localparam logic [1:0] WRAP_REPEAT = 2'd1;
  localparam logic [1:0] WRAP_MIRROR = 2'd2;

  localparam logic FILTER_NEAREST  = 1'b0;
  localparam logic FILTER_BILINEAR = 1'b1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_U,
    ST_MUL_V,
    ST_ADDR,
    ST_RD00,
    ST_RD10,
    ST_RD01,
    ST_RD11,
    ST_BLEND1,
    ST_BLEND2,
    ST_NEAR,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== src/tsw_lerp.sv =====
`default_nettype none

// per-channel blend of two rgba8 texels: (a*(S-w) + b*w + S/2) >> WEIGHT_BITS
module tsw_lerp #(
  parameter int WEIGHT_BITS = tsw_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic [tsw_pkg::TEXEL_W-1:0] a,
  input  wire logic [tsw_pkg::TEXEL_W-1:0] b,
  input  wire logic [WEIGHT_BITS-1:0]      w,
  output logic      [tsw_pkg::TEXEL_W-1:0] y
);

  localparam int CW = tsw_pkg::CHAN_W;
  localparam int SW = CW + WEIGHT_BITS + 2;
  localparam logic [WEIGHT_BITS:0] SCALE = (WEIGHT_BITS+1)'(1) << WEIGHT_BITS;
  localparam logic [SW-1:0]        HALF  = SW'(1) << (WEIGHT_BITS - 1);

  logic [WEIGHT_BITS:0] inv_w;

  assign inv_w = SCALE - {1'b0, w};

  for (genvar ch = 0; ch < tsw_pkg::NUM_CHAN; ch++) begin : g_chan
    logic [SW-1:0] sum;
    assign sum = SW'(a[ch*CW +: CW]) * SW'(inv_w)
               + SW'(b[ch*CW +: CW]) * SW'(w) + HALF;
    assign y[ch*CW +: CW] = CW'(sum >> WEIGHT_BITS);
  end

endmodule

`default_nettype wire

// ===== src/texture_sampler_wrap_filter.sv =====
`default_nettype none

// channel  | direction | handshake               | payload
// s        | in        | s_tvalid / s_tready     | s_tuser command, s_tdata load texel and u, v
// m        | out       | m_tvalid / m_tready     | m_tdata sampled rgba8
// cfg      | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// a load is written in its transfer cycle. a sample on a zero-sized image goes straight to the
// result; else it scales u then v on one shared multiplier, forms the indexes, and reads one
// texel (nearest) or four with three blends in one reused blend unit (bilinear) from the
// single-port texel memory, which gives one texel per cycle; then it loads the result.
// rst is synchronous; it clears the sequencer, the output valid and the configuration
// registers. the texel memory is not cleared. a result waiting on m_tready holds back only
// the next sample's final step, not its acceptance.
module texture_sampler_wrap_filter #(
  parameter int MAX_DIM         = tsw_pkg::MAX_DIM_DEF,
  parameter int COORD_FRAC_BITS = tsw_pkg::COORD_FRAC_BITS_DEF,
  parameter int WEIGHT_BITS     = tsw_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // texel_index[11:0], load_red[19:12], load_green[27:20], load_blue[35:28],
  // load_alpha[43:36], coord_u[75:44], coord_v[107:76], zero fill above
  input  wire logic [tsw_pkg::S_TDATA_W-1:0]      s_tdata,
  // command[0]
  input  wire logic                               s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic      [tsw_pkg::M_TDATA_W-1:0]      m_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tsw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tsw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int CFB   = COORD_FRAC_BITS;
  localparam int WB    = WEIGHT_BITS;
  localparam int CW    = CFB + 1;
  localparam int PW    = CW + IDX_W;
  localparam int TW    = tsw_pkg::TEXEL_W;
  localparam logic [31:0] ONE    = 32'(1) << CFB;
  localparam logic [PW:0] HALF   = (PW+1)'(1) << (CFB - 1);

  // configuration registers
  logic [1:0]                  wrap_mode;
  logic                        filter_mode;
  logic [tsw_pkg::SIZE_W-1:0]  tex_width;
  logic [tsw_pkg::SIZE_W-1:0]  tex_height;

  tsw_pkg::state_t state, state_next;

  // datapath registers
  logic [tsw_pkg::COORD_W-1:0] coord_u, coord_v;
  logic [PW-1:0]               px, py;
  logic [IDX_W-1:0]            x0, x1, y0, y1;
  logic [WB-1:0]               fx, fy;
  logic [TW-1:0]               tex_a, c0, c1, res;
  logic [TW-1:0]               rd_data;
  logic [TW-1:0]               mem [DEPTH];

  // combinational
  logic                        s_fire, out_free;
  logic [DIM_W-1:0]            eff_w, eff_h;
  logic                        size_zero;
  logic [IDX_W-1:0]            wm1, hm1;
  logic [tsw_pkg::COORD_W-1:0] mul_coord;
  logic [CW-1:0]               wrapped;
  logic [IDX_W-1:0]            mul_b;
  logic [PW-1:0]               product;
  logic [IDX_W:0]              xi, yi;
  logic [IDX_W-1:0]            x0_next, y0_next, x1_next, y1_next;
  logic [WB-1:0]               fx_next, fy_next;
  logic [IDX_W-1:0]            rd_x, rd_y;
  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [TW-1:0]               mem_wdata;
  logic [TW-1:0]               lerp_a, lerp_b, lerp_y;
  logic [WB-1:0]               lerp_w;

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W:0] v,
                                                 input logic [IDX_W-1:0] lim);
    logic [IDX_W-1:0] r;
    r = (v > {1'b0, lim}) ? lim : IDX_W'(v);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] v,
                                                input logic [IDX_W-1:0] lim);
    logic [IDX_W:0] inc;
    inc = {1'b0, v} + (IDX_W+1)'(1);
    return (inc > {1'b0, lim}) ? lim : IDX_W'(inc);
  endfunction

  assign cfg_ready = 1'b1;
  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // sizes above MAX_DIM saturate
  assign eff_w = ({25'd0, tex_width} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(tex_width);
  assign eff_h = ({25'd0, tex_height} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(tex_height);
  assign size_zero = (eff_w == '0) || (eff_h == '0);
  assign wm1 = IDX_W'(eff_w - DIM_W'(1));
  assign hm1 = IDX_W'(eff_h - DIM_W'(1));

  // shared wrap and multiply unit: u first, v in the next cycle
  always_comb begin
    mul_coord = (state == tsw_pkg::ST_MUL_V) ? coord_v : coord_u;
    mul_b     = (state == tsw_pkg::ST_MUL_V) ? hm1 : wm1;
    case (wrap_mode)
      tsw_pkg::WRAP_REPEAT: wrapped = {1'b0, mul_coord[CFB-1:0]};
      tsw_pkg::WRAP_MIRROR: begin
        if (mul_coord[CFB]) begin
          wrapped = CW'(ONE) - {1'b0, mul_coord[CFB-1:0]};
        end else begin
          wrapped = {1'b0, mul_coord[CFB-1:0]};
        end
      end
      default: begin
        if (mul_coord[tsw_pkg::COORD_W-1]) begin
          wrapped = '0;
        end else if (mul_coord > ONE) begin
          wrapped = CW'(ONE);
        end else begin
          wrapped = CW'(mul_coord);
        end
      end
    endcase
    product = PW'(wrapped) * PW'(mul_b);
  end

  // texel indexes and weights from the scaled positions
  always_comb begin
    xi = (IDX_W+1)'((((PW+1)'(px)) + ((filter_mode == tsw_pkg::FILTER_NEAREST) ?
          HALF : '0)) >> CFB);
    yi = (IDX_W+1)'((((PW+1)'(py)) + ((filter_mode == tsw_pkg::FILTER_NEAREST) ?
          HALF : '0)) >> CFB);
    x0_next = clamp_idx(xi, wm1);
    y0_next = clamp_idx(yi, hm1);
    x1_next = next_idx(x0_next, wm1);
    y1_next = next_idx(y0_next, hm1);
    fx_next = WB'({px[CFB-1:0], {WB{1'b0}}} >> CFB);
    fy_next = WB'({py[CFB-1:0], {WB{1'b0}}} >> CFB);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tsw_pkg::ST_IDLE: begin
        if (s_fire && s_tuser == tsw_pkg::CMD_SAMPLE) begin
          state_next = size_zero ? tsw_pkg::ST_OUT : tsw_pkg::ST_MUL_U;
        end
      end
      tsw_pkg::ST_MUL_U:   state_next = tsw_pkg::ST_MUL_V;
      tsw_pkg::ST_MUL_V:   state_next = tsw_pkg::ST_ADDR;
      tsw_pkg::ST_ADDR:    state_next = tsw_pkg::ST_RD00;
      tsw_pkg::ST_RD00: begin
        state_next = (filter_mode == tsw_pkg::FILTER_BILINEAR) ?
                     tsw_pkg::ST_RD10 : tsw_pkg::ST_NEAR;
      end
      tsw_pkg::ST_RD10:    state_next = tsw_pkg::ST_RD01;
      tsw_pkg::ST_RD01:    state_next = tsw_pkg::ST_RD11;
      tsw_pkg::ST_RD11:    state_next = tsw_pkg::ST_BLEND1;
      tsw_pkg::ST_BLEND1:  state_next = tsw_pkg::ST_BLEND2;
      tsw_pkg::ST_BLEND2:  state_next = tsw_pkg::ST_OUT;
      tsw_pkg::ST_NEAR:    state_next = tsw_pkg::ST_OUT;
      tsw_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = tsw_pkg::ST_IDLE;
        end
      end
      default:             state_next = tsw_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, memory port, blend operands
  always_comb begin
    s_tready  = (state == tsw_pkg::ST_IDLE);
    rd_x      = (state == tsw_pkg::ST_RD10 || state == tsw_pkg::ST_RD11) ? x1 : x0;
    rd_y      = (state == tsw_pkg::ST_RD01 || state == tsw_pkg::ST_RD11) ? y1 : y0;
    mem_we    = (state == tsw_pkg::ST_IDLE) && s_fire && (s_tuser == tsw_pkg::CMD_LOAD) &&
                ({20'd0, s_tdata[11:0]} < 32'(DEPTH));
    mem_wdata = s_tdata[43:12];
    if (state == tsw_pkg::ST_IDLE) begin
      mem_addr = AW'(s_tdata[11:0]);
    end else begin
      mem_addr = AW'(rd_y) * AW'(MAX_DIM) + AW'(rd_x);
    end
    lerp_a = (state == tsw_pkg::ST_BLEND2) ? c0 : tex_a;
    lerp_b = (state == tsw_pkg::ST_BLEND2) ? c1 : rd_data;
    lerp_w = (state == tsw_pkg::ST_BLEND2) ? fy : fx;
  end

  tsw_lerp #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_lerp (
    .a (lerp_a),
    .b (lerp_b),
    .w (lerp_w),
    .y (lerp_y)
  );

  // texel memory, single port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tsw_pkg::ST_IDLE;
      m_tvalid    <= 1'b0;
      wrap_mode   <= tsw_pkg::WRAP_CLAMP;
      filter_mode <= tsw_pkg::FILTER_NEAREST;
      tex_width   <= '0;
      tex_height  <= '0;
    end else begin
      state <= state_next;
      if (state == tsw_pkg::ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tsw_pkg::REG_WRAP_MODE:   wrap_mode   <= cfg_data[1:0];
          tsw_pkg::REG_FILTER_MODE: filter_mode <= cfg_data[0];
          tsw_pkg::REG_TEX_WIDTH:   tex_width   <= cfg_data;
          tsw_pkg::REG_TEX_HEIGHT:  tex_height  <= cfg_data;
          default:                  wrap_mode   <= wrap_mode;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      coord_u <= s_tdata[75:44];
      coord_v <= s_tdata[107:76];
      res     <= '0;
    end
    if (state == tsw_pkg::ST_MUL_U) begin
      px <= product;
    end
    if (state == tsw_pkg::ST_MUL_V) begin
      py <= product;
    end
    if (state == tsw_pkg::ST_ADDR) begin
      x0 <= x0_next;
      y0 <= y0_next;
      x1 <= x1_next;
      y1 <= y1_next;
      fx <= fx_next;
      fy <= fy_next;
    end
    if (state == tsw_pkg::ST_RD10 || state == tsw_pkg::ST_RD11) begin
      tex_a <= rd_data;
    end
    if (state == tsw_pkg::ST_RD01) begin
      c0 <= lerp_y;
    end
    if (state == tsw_pkg::ST_BLEND1) begin
      c1 <= lerp_y;
    end
    if (state == tsw_pkg::ST_BLEND2) begin
      res <= lerp_y;
    end
    if (state == tsw_pkg::ST_NEAR) begin
      res <= rd_data;
    end
    if (state == tsw_pkg::ST_OUT && out_free) begin
      m_tdata <= res;
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != tsw_pkg::ST_IDLE |-> !s_tready)
    else $error("input taken while a sample is in progress");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tuser == tsw_pkg::CMD_LOAD |=> state == tsw_pkg::ST_IDLE)
    else $error("load transfer started the sample sequence");

  a_zero_size_direct: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tuser == tsw_pkg::CMD_SAMPLE && size_zero |=> state == tsw_pkg::ST_OUT)
    else $error("empty image sample did not go straight to the result");

  a_neighbours_in_image: assert property (@(posedge clk) disable iff (rst)
    state == tsw_pkg::ST_RD00 |-> x1 <= wm1 && y1 <= hm1 && x0 <= x1 && y0 <= y1)
    else $error("neighbour texel outside the image");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    state == tsw_pkg::ST_OUT && out_free |=> m_tvalid && state == tsw_pkg::ST_IDLE)
    else $error("result not presented after the final step");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int FRAC = tsw_pkg::COORD_FRAC_BITS_DEF;
  localparam int WB = tsw_pkg::WEIGHT_BITS_DEF;
  localparam int MAXD = tsw_pkg::MAX_DIM_DEF;
  localparam int ONE = 1 << FRAC;
  localparam int WSCALE = 1 << WB;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 70;
  // margin beyond the longest (bilinear) sample sequence
  localparam int IDLE_CYCLES = 16;
  localparam int LIMIT_NS = 10_000_000;
  // spare wrap code, the block treats it as clamp
  localparam logic [1:0] WRAP_SPARE = 2'd3;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
  typedef enum logic [1:0] {RDY_FULL, RDY_COIN, RDY_COMB, RDY_SPARSE} rdy_pattern_t;

  typedef struct {
    row_kind_t kind;
    logic [tsw_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [tsw_pkg::CFG_DATA_W-1:0] reg_val;
    logic cmd;
    logic [tsw_pkg::INDEX_W-1:0] idx;
    logic [tsw_pkg::TEXEL_W-1:0] texel;
    logic [tsw_pkg::COORD_W-1:0] u;
    logic [tsw_pkg::COORD_W-1:0] v;
    bit has_exp;
    logic [tsw_pkg::TEXEL_W-1:0] exp_colour;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [tsw_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [tsw_pkg::M_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tsw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tsw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the block's registers and texture store
  logic [1:0] wrap_sel = tsw_pkg::WRAP_CLAMP;
  logic filt_sel = tsw_pkg::FILTER_NEAREST;
  logic [tsw_pkg::SIZE_W-1:0] width_reg = '0;
  logic [tsw_pkg::SIZE_W-1:0] height_reg = '0;
  logic [tsw_pkg::TEXEL_W-1:0] texel_mem [MAXD*MAXD];
  bit loaded [MAXD*MAXD];

  logic [tsw_pkg::TEXEL_W-1:0] colour_q [$];
  dir_row_t dir_rows [$];
  int mismatches = 0;
  int burst_left = 0;
  rdy_pattern_t rdy_pat = RDY_FULL;
  int rdy_left = 0;
  int unsigned rdy_tick = 0;
  string chan_name [tsw_pkg::NUM_CHAN] = '{"red", "green", "blue", "alpha"};

  texture_sampler_wrap_filter dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int clip_dim(logic [tsw_pkg::SIZE_W-1:0] d);
    return (d > MAXD) ? MAXD : int'(d);
  endfunction

  function automatic logic [31:0] wrap_fixed(logic [tsw_pkg::COORD_W-1:0] raw);
    logic [31:0] frac;
    frac = raw & (ONE - 1);
    case (wrap_sel)
      tsw_pkg::WRAP_REPEAT: return frac;
      // odd periods run backwards, a zero fraction there lands on one
      tsw_pkg::WRAP_MIRROR: return raw[FRAC] ? (ONE - frac) : frac;
      default: begin
        if (raw[tsw_pkg::COORD_W-1]) return 0;
        if (raw > ONE) return ONE;
        return raw;
      end
    endcase
  endfunction

  function automatic logic [tsw_pkg::TEXEL_W-1:0] blend(logic [tsw_pkg::TEXEL_W-1:0] a,
                                                        logic [tsw_pkg::TEXEL_W-1:0] b,
                                                        int unsigned w);
    logic [tsw_pkg::TEXEL_W-1:0] res;
    int unsigned ca;
    int unsigned cb;
    int ch;
    for (ch = 0; ch < tsw_pkg::NUM_CHAN; ch++) begin
      ca = a[tsw_pkg::CHAN_W*ch +: tsw_pkg::CHAN_W];
      cb = b[tsw_pkg::CHAN_W*ch +: tsw_pkg::CHAN_W];
      res[tsw_pkg::CHAN_W*ch +: tsw_pkg::CHAN_W] =
        tsw_pkg::CHAN_W'((ca * (WSCALE - w) + cb * w + WSCALE / 2) >> WB);
    end
    return res;
  endfunction

  function automatic logic [tsw_pkg::TEXEL_W-1:0] sample_colour(
      logic [tsw_pkg::COORD_W-1:0] u, logic [tsw_pkg::COORD_W-1:0] v);
    int ew;
    int eh;
    int x0;
    int y0;
    int x1;
    int y1;
    int unsigned fx;
    int unsigned fy;
    longint unsigned px;
    longint unsigned py;
    logic [tsw_pkg::TEXEL_W-1:0] c0;
    logic [tsw_pkg::TEXEL_W-1:0] c1;
    ew = clip_dim(width_reg);
    eh = clip_dim(height_reg);
    if (ew == 0 || eh == 0) return '0;
    px = longint'(wrap_fixed(u)) * longint'(ew - 1);
    py = longint'(wrap_fixed(v)) * longint'(eh - 1);
    if (filt_sel == tsw_pkg::FILTER_NEAREST) begin
      x0 = int'((px + ONE / 2) >> FRAC);
      y0 = int'((py + ONE / 2) >> FRAC);
      if (x0 > ew - 1) x0 = ew - 1;
      if (y0 > eh - 1) y0 = eh - 1;
      return texel_mem[y0*MAXD + x0];
    end
    x0 = int'(px >> FRAC);
    y0 = int'(py >> FRAC);
    if (x0 > ew - 1) x0 = ew - 1;
    if (y0 > eh - 1) y0 = eh - 1;
    x1 = (x0 + 1 > ew - 1) ? ew - 1 : x0 + 1;
    y1 = (y0 + 1 > eh - 1) ? eh - 1 : y0 + 1;
    fx = int'((px & (ONE - 1)) >> (FRAC - WB));
    fy = int'((py & (ONE - 1)) >> (FRAC - WB));
    c0 = blend(texel_mem[y0*MAXD + x0], texel_mem[y0*MAXD + x1], fx);
    c1 = blend(texel_mem[y1*MAXD + x0], texel_mem[y1*MAXD + x1], fx);
    return blend(c0, c1, fy);
  endfunction

  function automatic dir_row_t make_cfg(logic [tsw_pkg::CFG_IDX_W-1:0] idx,
                                        logic [tsw_pkg::CFG_DATA_W-1:0] val);
    dir_row_t r;
    r = '{ROW_CFG, idx, val, tsw_pkg::CMD_LOAD, '0, '0, '0, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t make_load(logic [tsw_pkg::INDEX_W-1:0] idx,
                                         logic [tsw_pkg::TEXEL_W-1:0] texel);
    dir_row_t r;
    r = '{ROW_ITEM, '0, '0, tsw_pkg::CMD_LOAD, idx, texel, '1, '1, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t make_sample(logic [tsw_pkg::COORD_W-1:0] u,
                                           logic [tsw_pkg::COORD_W-1:0] v,
                                           bit has_exp,
                                           logic [tsw_pkg::TEXEL_W-1:0] exp_colour);
    dir_row_t r;
    r = '{ROW_ITEM, '0, '0, tsw_pkg::CMD_SAMPLE, '1, '0, u, v, has_exp, exp_colour};
    return r;
  endfunction

  function automatic logic [tsw_pkg::COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: return tsw_pkg::COORD_W'(int'($urandom_range(0, 4 * ONE)) - 2 * ONE);
      3: return $urandom_range(0, ONE);
      // close to a period boundary
      4: return tsw_pkg::COORD_W'((int'($urandom_range(0, 6)) - 3) * ONE +
                                  int'($urandom_range(0, 2)) - 1);
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return ONE;
          3: return ONE / 2;
          4: return -ONE;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 7))
      0: return 1;
      1: return $urandom_range(9, 24);
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  task automatic report(string what, logic [tsw_pkg::CHAN_W-1:0] want,
                        logic [tsw_pkg::CHAN_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t tb: mismatch %s expected %02h got %02h", $realtime, what, want, got);
  endtask

  // burst pacing, with an occasional hold-off until the pipe has emptied
  task automatic pace();
    int gap;
    bit hold;
    gap = 0;
    hold = ($urandom_range(0, 299) == 0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0 || hold) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (hold) begin
        do @(posedge clk); while (colour_q.size() != 0);
      end
    end
  endtask

  task automatic send_item(logic cmd, logic [tsw_pkg::INDEX_W-1:0] idx,
                           logic [tsw_pkg::TEXEL_W-1:0] texel,
                           logic [tsw_pkg::COORD_W-1:0] u, logic [tsw_pkg::COORD_W-1:0] v,
                           bit has_exp, logic [tsw_pkg::TEXEL_W-1:0] exp_colour);
    pace();
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {{(tsw_pkg::S_TDATA_W - 108){1'b0}}, v, u, texel, idx};
    do @(posedge clk); while (!s_tready);
    if (cmd == tsw_pkg::CMD_LOAD) begin
      texel_mem[idx] = texel;
      loaded[idx] = 1'b1;
    end else begin
      colour_q.push_back(has_exp ? exp_colour : sample_colour(u, v));
    end
  endtask

  task automatic write_reg(logic [tsw_pkg::CFG_IDX_W-1:0] idx,
                           logic [tsw_pkg::CFG_DATA_W-1:0] val, bit is_last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tsw_pkg::REG_WRAP_MODE: wrap_sel = val[1:0];
      tsw_pkg::REG_FILTER_MODE: filt_sel = val[0];
      tsw_pkg::REG_TEX_WIDTH: width_reg = val;
      default: height_reg = val;
    endcase
    if (is_last) cfg_valid <= 1'b0;
  endtask

  // stop sending and let the block fall idle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (colour_q.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [1:0] wrap, logic filt, int w, int h, int n);
    int ew;
    int eh;
    int x;
    int y;
    int k;
    logic [tsw_pkg::INDEX_W-1:0] idx;
    drain();
    write_reg(tsw_pkg::REG_WRAP_MODE, tsw_pkg::CFG_DATA_W'(wrap), 1'b0);
    write_reg(tsw_pkg::REG_FILTER_MODE, tsw_pkg::CFG_DATA_W'(filt), 1'b0);
    write_reg(tsw_pkg::REG_TEX_WIDTH, tsw_pkg::CFG_DATA_W'(w), 1'b0);
    write_reg(tsw_pkg::REG_TEX_HEIGHT, tsw_pkg::CFG_DATA_W'(h), 1'b1);
    ew = clip_dim(tsw_pkg::SIZE_W'(w));
    eh = clip_dim(tsw_pkg::SIZE_W'(h));
    // every texel the samples can reach gets written first
    for (y = 0; y < eh; y++)
      for (x = 0; x < ew; x++)
        if (!loaded[y*MAXD + x])
          send_item(tsw_pkg::CMD_LOAD, tsw_pkg::INDEX_W'(y*MAXD + x), $urandom(),
                    $urandom(), $urandom(), 1'b0, '0);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        if (ew > 0 && eh > 0 && $urandom_range(0, 1) == 0)
          idx = tsw_pkg::INDEX_W'($urandom_range(0, eh - 1) * MAXD +
                                  $urandom_range(0, ew - 1));
        else
          idx = tsw_pkg::INDEX_W'($urandom());
        send_item(tsw_pkg::CMD_LOAD, idx, $urandom(), $urandom(), $urandom(), 1'b0, '0);
      end else begin
        send_item(tsw_pkg::CMD_SAMPLE, tsw_pkg::INDEX_W'($urandom()), $urandom(),
                  pick_coord(), pick_coord(), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_pat = rdy_pattern_t'($urandom_range(0, 3));
      rdy_left = $urandom_range(16, 256);
    end else begin
      rdy_left--;
    end
    rdy_tick++;
    case (rdy_pat)
      RDY_FULL: m_tready <= 1'b1;
      RDY_COIN: m_tready <= 1'($urandom_range(0, 1));
      RDY_COMB: m_tready <= (rdy_tick % 5) != 0;
      default: m_tready <= (rdy_tick % 16) < 4;
    endcase
  end

  logic [tsw_pkg::TEXEL_W-1:0] want;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (colour_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t tb: result %08h with nothing outstanding", $realtime, m_tdata);
      end else begin
        want = colour_q.pop_front();
        for (int ch = 0; ch < tsw_pkg::NUM_CHAN; ch++)
          if (m_tdata[tsw_pkg::CHAN_W*ch +: tsw_pkg::CHAN_W] !==
              want[tsw_pkg::CHAN_W*ch +: tsw_pkg::CHAN_W])
            report(chan_name[ch], want[tsw_pkg::CHAN_W*ch +: tsw_pkg::CHAN_W],
                   m_tdata[tsw_pkg::CHAN_W*ch +: tsw_pkg::CHAN_W]);
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    dir_row_t r;
    int i;
    int p;
    // nothing sized after reset, so transparent black
    dir_rows.push_back(make_sample('0, '0, 1'b1, '0));
    dir_rows.push_back(make_load(12'd0, 32'hffff_ffff));
    dir_rows.push_back(make_load(12'd1, 32'h0000_0000));
    dir_rows.push_back(make_load(12'd64, 32'h8040_2010));
    dir_rows.push_back(make_load(12'd65, 32'h01ff_7fc3));
    dir_rows.push_back(make_load(12'hfff, 32'hffff_ffff));
    dir_rows.push_back(make_cfg(tsw_pkg::REG_TEX_WIDTH, 7'd2));
    dir_rows.push_back(make_cfg(tsw_pkg::REG_TEX_HEIGHT, 7'd2));
    dir_rows.push_back(make_sample('0, '0, 1'b0, '0));
    dir_rows.push_back(make_sample(32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0));
    dir_rows.push_back(make_sample(32'h8000_0000, 32'h8000_0000, 1'b0, '0));
    dir_rows.push_back(make_sample(32'h0000_8000, 32'h0000_7fff, 1'b0, '0));
    dir_rows.push_back(make_cfg(tsw_pkg::REG_WRAP_MODE,
                                tsw_pkg::CFG_DATA_W'(tsw_pkg::WRAP_REPEAT)));
    dir_rows.push_back(make_sample(32'h0001_8000, 32'hffff_8000, 1'b0, '0));
    dir_rows.push_back(make_cfg(tsw_pkg::REG_WRAP_MODE,
                                tsw_pkg::CFG_DATA_W'(tsw_pkg::WRAP_MIRROR)));
    dir_rows.push_back(make_sample(32'h0001_0000, 32'h0001_0000, 1'b0, '0));
    dir_rows.push_back(make_sample(32'hffff_4000, 32'h0002_c000, 1'b0, '0));
    dir_rows.push_back(make_cfg(tsw_pkg::REG_WRAP_MODE, tsw_pkg::CFG_DATA_W'(WRAP_SPARE)));
    dir_rows.push_back(make_sample(32'h8000_0000, 32'h0001_0001, 1'b0, '0));
    dir_rows.push_back(make_cfg(tsw_pkg::REG_FILTER_MODE,
                                tsw_pkg::CFG_DATA_W'(tsw_pkg::FILTER_BILINEAR)));
    dir_rows.push_back(make_sample(32'h0000_8000, 32'h0000_8000, 1'b0, '0));
    dir_rows.push_back(make_sample(32'h7fff_ffff, '0, 1'b0, '0));
    dir_rows.push_back(make_sample(32'h0000_4000, 32'h0000_c000, 1'b0, '0));
    dir_rows.push_back(make_cfg(tsw_pkg::REG_TEX_WIDTH, 7'd0));
    dir_rows.push_back(make_sample(32'h0000_8000, 32'h0000_8000, 1'b1, '0));
    dir_rows.push_back(make_cfg(tsw_pkg::REG_TEX_WIDTH, 7'd2));
    dir_rows.push_back(make_cfg(tsw_pkg::REG_TEX_HEIGHT, 7'd0));
    dir_rows.push_back(make_sample(32'h0000_8000, 32'h0000_8000, 1'b1, '0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < dir_rows.size(); i++) begin
      r = dir_rows[i];
      if (r.kind == ROW_CFG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_CFG) drain();
        write_reg(r.reg_idx, r.reg_val,
                  (i == dir_rows.size() - 1) || (dir_rows[i+1].kind != ROW_CFG));
      end else begin
        send_item(r.cmd, r.idx, r.texel, r.u, r.v, r.has_exp, r.exp_colour);
      end
    end

    // full-size and oversized images are kept to a few rows or columns
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: run_phase(tsw_pkg::WRAP_CLAMP, tsw_pkg::FILTER_NEAREST, 1, 1, PHASE_ITEMS);
        1: run_phase(tsw_pkg::WRAP_REPEAT, tsw_pkg::FILTER_BILINEAR, 0, 5, PHASE_ITEMS);
        2: run_phase(tsw_pkg::WRAP_MIRROR, tsw_pkg::FILTER_NEAREST, 7, 0, PHASE_ITEMS);
        PHASES - 3: run_phase(tsw_pkg::WRAP_MIRROR, tsw_pkg::FILTER_BILINEAR, MAXD, 2,
                              PHASE_ITEMS);
        PHASES - 2: run_phase(tsw_pkg::WRAP_REPEAT, tsw_pkg::FILTER_BILINEAR, 127, 3,
                              PHASE_ITEMS);
        PHASES - 1: run_phase(WRAP_SPARE, tsw_pkg::FILTER_NEAREST, 2, 127, PHASE_ITEMS);
        default: run_phase(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           pick_size(), pick_size(), PHASE_ITEMS);
      endcase
    end

    drain();
    if (mismatches == 0 && colour_q.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tsw_pkg.sv
src/tsw_lerp.sv
src/texture_sampler_wrap_filter.sv
verif/tb.sv
